FILE: hw/rtl/crowding_nearest_replacement_core_macros.svh
// assertion macros for the crowding replacement core
// no dependencies
`ifndef CROWDING_NEAREST_REPLACEMENT_CORE_MACROS_SVH
`define CROWDING_NEAREST_REPLACEMENT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CNR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CNR_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CNR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CNR_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: hw/rtl/cnr_pkg.sv
// shared types and constants for the crowding replacement core
// no dependencies
package cnr_pkg;
  localparam int POP_SIZE = 32;
  localparam int DIM = 64;
  localparam int EW = 5;
  localparam int DW = 6;
  localparam int AW = EW + DW;
  localparam int DISTW = 56;

  typedef enum logic [2:0] {
    OP_WR_ELEM = 3'd0, OP_WR_FIT = 3'd1, OP_WR_CAND = 3'd2,
    OP_SELECT = 3'd3, OP_RD_ELEM = 3'd4, OP_RD_FIT = 3'd5,
    OP_NOP6 = 3'd6, OP_NOP7 = 3'd7
  } op_t;

  localparam logic CFG_DIMS = 1'b0;
  localparam logic CFG_ENTRIES = 1'b1;

  typedef struct packed {
    op_t op;
    logic [EW-1:0] entry;
    logic [DW-1:0] elem;
    logic signed [23:0] value;
    logic signed [31:0] fitness;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [EW-1:0] nearest;
    logic replaced;
    logic [DISTW-1:0] near_dist;
  } res_t;
endpackage

FILE: hw/rtl/cnr_front.sv
// front: accepts items, holds config registers, queues commands
// depends on cnr_pkg
module cnr_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  cnr_pkg::cmd_t in_cmd,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [31:0] cfg_data,
  output logic [6:0] dims_r,
  output logic [5:0] ents_r,
  output logic q_valid,
  input  logic q_ready,
  output cnr_pkg::cmd_t q_cmd
);
  cnr_pkg::cmd_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic push, pop;

  assign cfg_ready = 1'b1;
  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = buf_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
      dims_r <= 7'd64; ents_r <= 6'd32;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      if (cfg_valid && cfg_index[7:1] == 7'd0) begin
        if (cfg_index[0] == cnr_pkg::CFG_DIMS) dims_r <= cfg_data[6:0];
        else ents_r <= cfg_data[5:0];
      end
    end
  end

  `include "crowding_nearest_replacement_core_macros.svh"
  `CNR_NEVER(a_q_over, clk, rst_n, cnt_r == 2'd3, "queue count overflow")
  `CNR_ASSERT(a_q_full, clk, rst_n, (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2, "queue lost item")
  `CNR_NEVER(a_q_under, clk, rst_n, pop && cnt_r == 2'd0, "pop from empty queue")
endmodule

FILE: hw/rtl/cnr_back.sv
// back: stores population, runs the nearest search and replacement copy
// depends on cnr_pkg
module cnr_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  cnr_pkg::cmd_t q_cmd,
  input  logic [6:0] dims_cfg,
  input  logic [5:0] ents_cfg,
  output logic res_valid,
  input  logic res_ready,
  output cnr_pkg::res_t res
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_LAST = 6'b000100,
    S_FIT = 6'b001000, S_COPY = 6'b010000, S_OUT = 6'b100000
  } st_t;
  st_t st_r;

  logic signed [23:0] pop_mem [cnr_pkg::POP_SIZE*cnr_pkg::DIM];
  logic signed [23:0] cand_mem [cnr_pkg::DIM];
  logic signed [31:0] fit_mem [cnr_pkg::POP_SIZE];

  cnr_pkg::cmd_t cmd_r;
  logic [cnr_pkg::EW-1:0] e_r, near_r;
  logic [cnr_pkg::DW-1:0] d_r;
  logic [cnr_pkg::DW:0] dims;
  logic [cnr_pkg::EW:0] ents;
  logic signed [23:0] pe_q, ce_q;
  logic signed [31:0] fit_q;
  logic p_v_r, p_last_d_r, p_last_e_r;
  logic [cnr_pkg::EW-1:0] p_e_r;
  logic signed [24:0] diff;
  logic [49:0] sq_r;
  logic s_v_r, s_last_d_r, s_last_e_r;
  logic [cnr_pkg::EW-1:0] s_e_r;
  logic [cnr_pkg::DISTW-1:0] acc_r, best_r, acc_sum;
  logic first_r;
  logic [cnr_pkg::AW-1:0] raddr;
  logic [cnr_pkg::DW-1:0] caddr;
  logic last_d, last_e, issue;
  logic [cnr_pkg::DW-1:0] cp_r;
  logic cp_v_r;
  logic [cnr_pkg::DW-1:0] cp_d_r;

  assign dims = (dims_cfg == 7'd0) ? 7'd1 : (dims_cfg > 7'd64 ? 7'd64 : dims_cfg);
  assign ents = (ents_cfg == 6'd0) ? 6'd1 : (ents_cfg > 6'd32 ? 6'd32 : ents_cfg);
  assign last_d = ({1'b0, d_r} == dims - 7'd1);
  assign last_e = ({1'b0, e_r} == ents - 6'd1);
  assign issue = (st_r == S_SCAN);
  assign q_ready = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);

  always_comb begin
    raddr = {q_cmd.entry, q_cmd.elem};
    caddr = q_cmd.elem;
    if (st_r == S_SCAN) begin
      raddr = {e_r, d_r}; caddr = d_r;
    end else if (st_r == S_COPY) begin
      caddr = cp_r; raddr = {near_r, cp_r};
    end
  end

  // single write port; copy writes use the candidate element read in the previous cycle
  always_ff @(posedge clk) begin
    pe_q <= pop_mem[raddr];
    ce_q <= cand_mem[caddr];
    if (st_r == S_IDLE && q_valid && q_cmd.op == cnr_pkg::OP_WR_ELEM)
      pop_mem[{q_cmd.entry, q_cmd.elem}] <= q_cmd.value;
    else if (cp_v_r) pop_mem[{near_r, cp_d_r}] <= ce_q;
    if (st_r == S_IDLE && q_valid && q_cmd.op == cnr_pkg::OP_WR_CAND)
      cand_mem[q_cmd.elem] <= q_cmd.value;
  end

  always_ff @(posedge clk) begin
    fit_q <= fit_mem[(st_r == S_IDLE) ? q_cmd.entry : near_r];
    if (st_r == S_IDLE && q_valid && q_cmd.op == cnr_pkg::OP_WR_FIT)
      fit_mem[q_cmd.entry] <= q_cmd.fitness;
    else if (st_r == S_FIT && fit_q > cmd_r.fitness)
      fit_mem[near_r] <= cmd_r.fitness;
  end

  assign diff = {ce_q[23], ce_q} - {pe_q[23], pe_q};
  assign acc_sum = (first_r ? '0 : acc_r) + {6'd0, sq_r};

  always_ff @(posedge clk) begin
    p_e_r <= e_r; p_last_d_r <= last_d; p_last_e_r <= last_e;
    sq_r <= 50'(diff * diff);
    s_e_r <= p_e_r; s_last_d_r <= p_last_d_r; s_last_e_r <= p_last_e_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; p_v_r <= 1'b0; s_v_r <= 1'b0; cp_v_r <= 1'b0;
    end else begin
      p_v_r <= issue;
      s_v_r <= p_v_r;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          cmd_r <= q_cmd;
          res <= '0;
          if (q_cmd.op == cnr_pkg::OP_SELECT) begin
            st_r <= S_SCAN; e_r <= '0; d_r <= '0; first_r <= 1'b1;
            near_r <= '0;
          end else st_r <= S_LAST;
        end
        S_SCAN: begin
          if (last_d) begin
            d_r <= '0;
            if (last_e) st_r <= S_LAST; else e_r <= e_r + 5'd1;
          end else d_r <= d_r + 6'd1;
        end
        S_LAST: begin
          if (cmd_r.op == cnr_pkg::OP_SELECT) begin
            if (!p_v_r && !s_v_r) begin
              st_r <= S_FIT; res.nearest <= near_r; res.near_dist <= best_r;
            end
          end else begin
            if (cmd_r.op == cnr_pkg::OP_RD_ELEM) res.read_data <= 32'(pe_q);
            else if (cmd_r.op == cnr_pkg::OP_RD_FIT) res.read_data <= fit_q;
            st_r <= S_OUT;
          end
        end
        // replacement is decided once, before the fitness entry is overwritten
        S_FIT: begin
          cp_r <= '0;
          if (fit_q > cmd_r.fitness) begin
            res.replaced <= 1'b1; st_r <= S_COPY;
          end else st_r <= S_OUT;
        end
        S_COPY: begin
          if (cp_v_r && cp_d_r == 6'(cnr_pkg::DIM - 1)) begin
            cp_v_r <= 1'b0; st_r <= S_OUT;
          end else begin
            cp_v_r <= 1'b1; cp_d_r <= cp_r;
            cp_r <= cp_r + 6'd1;
          end
        end
        S_OUT: if (res_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
      if (s_v_r) begin
        acc_r <= acc_sum; first_r <= s_last_d_r;
        if (s_last_d_r && (s_e_r == '0 || acc_sum < best_r)) begin
          best_r <= acc_sum; near_r <= s_e_r;
        end
      end
    end
  end

  `include "crowding_nearest_replacement_core_macros.svh"
  `CNR_NEVER(a_rep_nosel, clk, rst_n, res_valid && res.replaced && cmd_r.op != cnr_pkg::OP_SELECT, "replace without select")
  `CNR_ASSERT(a_out_hold, clk, rst_n, (res_valid && !res_ready) |=> res_valid && $stable(res), "result dropped")
  `CNR_NEVER(a_near_rng, clk, rst_n, res_valid && {1'b0, res.nearest} >= ents, "nearest out of range")
endmodule

FILE: hw/rtl/crowding_nearest_replacement_core.sv
// top level of the crowding nearest replacement core
// depends on cnr_pkg, cnr_front, cnr_back
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata: op,entry,elem,value,fitness
//   out_    | out | out_tvalid/tready  | tdata: read_data,nearest,replaced,dist
//   cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
// loads and reads pass through the back sequencer states S_IDLE, S_LAST and S_OUT
// select scans entries*dims elements on the single element read port, then
// copies the candidate over the nearest entry when the candidate's fitness is lower
// rst_n is synchronous; stored vectors are not cleared
// a two-deep command queue lets the input run ahead of a stalled output
module crowding_nearest_replacement_core (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [71:0] in_tdata,  // op[2:0] entry[7:3] elem[13:8] value[37:14] fitness[69:38]
  output logic out_tvalid,
  input  logic out_tready,
  output logic [95:0] out_tdata, // read_data[31:0] nearest[36:32] replaced[37] dist[93:38]
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [31:0] cfg_data
);
  cnr_pkg::cmd_t in_cmd, q_cmd;
  cnr_pkg::res_t res;
  logic q_valid, q_ready;
  logic [6:0] dims;
  logic [5:0] ents;

  assign in_cmd.op = cnr_pkg::op_t'(in_tdata[2:0]);
  assign in_cmd.entry = in_tdata[7:3];
  assign in_cmd.elem = in_tdata[13:8];
  assign in_cmd.value = in_tdata[37:14];
  assign in_cmd.fitness = in_tdata[69:38];
  assign out_tdata = {2'b00, res.near_dist, res.replaced, res.nearest, res.read_data};

  cnr_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_cmd, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .dims_r(dims), .ents_r(ents), .q_valid, .q_ready, .q_cmd
  );
  cnr_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .dims_cfg(dims), .ents_cfg(ents),
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );
endmodule
